### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### rtl/wbps_pkg.sv
// Shared constants and types for the wildcard byte pattern scanner.
`timescale 1ns / 1ps
package wbps_pkg;

    localparam int MAX_PATTERN_BYTES = 16;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 5;
    localparam int CNT_W     = 32;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int IDX_W     = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN_BYTES);

    typedef logic [MAX_PATTERN_BYTES-1:0][BYTE_W-1:0] t_window;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LOW    = 2'd0,
        REG_PATTERN_HIGH   = 2'd1,
        REG_PATTERN_LENGTH = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] offset;
    } t_match;

endpackage

### rtl/wbps_match.sv
// Parallel wildcard compare of the byte window against the signature.
`timescale 1ns / 1ps
module wbps_match (
    input  wbps_pkg::t_window                i_window,
    input  wbps_pkg::t_window                i_pattern,
    input  logic [wbps_pkg::LEN_W-1:0]       i_length,
    input  logic [wbps_pkg::CNT_W-1:0]       i_count,
    output wbps_pkg::t_match                 o_match
);

    always_comb begin
        logic [wbps_pkg::LEN_W-1:0] lc;
        logic [wbps_pkg::LEN_W-1:0] lw;
        logic [wbps_pkg::LEN_W-1:0] idx;
        logic                       ok;
        lc  = (i_length > wbps_pkg::MAX_LEN) ? wbps_pkg::MAX_LEN : i_length;
        lw  = (lc == '0) ? wbps_pkg::LEN_W'(1) : lc;
        ok  = (i_count >= wbps_pkg::CNT_W'(lw));
        idx = '0;
        // pattern byte j lines up with window entry lc-1-j (entry 0 newest)
        for (int j = 0; j < wbps_pkg::MAX_PATTERN_BYTES; j++) begin
            idx = lc - wbps_pkg::LEN_W'(1) - wbps_pkg::LEN_W'(j);
            if ((wbps_pkg::LEN_W'(j) < lc) && (i_pattern[j] != '0) &&
                (i_window[idx[wbps_pkg::IDX_W-1:0]] != i_pattern[j])) begin
                ok = 1'b0;
            end
        end
        o_match.hit    = ok;
        o_match.offset = i_count - wbps_pkg::CNT_W'(lw);
    end

endmodule

### rtl/wildcard_byte_pattern_scan_unit.sv
// Top level of the wildcard byte pattern scanner.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------
//  input    | i_in_valid / o_in_ready  | i_data_byte, i_last
//  result   | o_out_valid / i_out_ready| o_found, o_match_offset
//  config   | i_cfg_we (no wait)       | i_cfg_index, i_cfg_data
//
// One byte per cycle while the result is not stalled; a request passes through
// the input register, and its result, if any, goes on to the result register.
// The window compare is one pass of parallel byte compares plus a 32-bit
// subtract and compare. Reset is synchronous and clears scan state and config.
// A stalled result holds the input register, which holds o_in_ready low.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wildcard_byte_pattern_scan_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [wbps_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic                              i_last,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic [wbps_pkg::CNT_W-1:0]        o_match_offset,
    input  logic                              i_cfg_we,
    input  logic [wbps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wbps_pkg::CFG_W-1:0]        i_cfg_data
);

    logic [wbps_pkg::CFG_W-1:0]  r_pat_low;
    logic [wbps_pkg::CFG_W-1:0]  r_pat_high;
    logic [wbps_pkg::LEN_W-1:0]  r_pat_len;

    logic                        r_s1_valid;
    logic [wbps_pkg::BYTE_W-1:0] r_s1_byte;
    logic                        r_s1_last;

    wbps_pkg::t_window           r_win, n_win;
    logic [wbps_pkg::CNT_W-1:0]  r_count, n_count;
    logic                        r_matched;

    logic                        r_out_valid;
    logic                        r_found;
    logic [wbps_pkg::CNT_W-1:0]  r_offset;

    logic                        out_free;
    logic                        s1_fire;
    logic                        in_fire;
    logic                        emit;
    wbps_pkg::t_match            match;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_win[0] = r_s1_byte;
        for (int k = 1; k < wbps_pkg::MAX_PATTERN_BYTES; k++) begin
            n_win[k] = r_win[k-1];
        end
        n_count = (r_count == '1) ? r_count : r_count + wbps_pkg::CNT_W'(1);
    end

    wbps_match u_match (
        .i_window  (n_win),
        .i_pattern ({r_pat_high, r_pat_low}),
        .i_length  (r_pat_len),
        .i_count   (n_count),
        .o_match   (match)
    );

    assign emit = s1_fire && !r_matched && (match.hit || r_s1_last);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_pat_len  <= wbps_pkg::LEN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wbps_pkg::REG_PATTERN_LOW:    r_pat_low  <= i_cfg_data;
                wbps_pkg::REG_PATTERN_HIGH:   r_pat_high <= i_cfg_data;
                wbps_pkg::REG_PATTERN_LENGTH: r_pat_len  <= i_cfg_data[wbps_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_byte <= i_data_byte;
            r_s1_last <= i_last;
        end
    end

    // scan state; window entries beyond the count never decide a hit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_matched <= 1'b0;
        end else if (s1_fire) begin
            if (r_s1_last) begin
                r_count   <= '0;
                r_matched <= 1'b0;
            end else if (!r_matched) begin
                r_count   <= n_count;
                r_matched <= match.hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && !r_matched) begin
            r_win <= n_win;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_found  <= match.hit;
            r_offset <= match.hit ? match.offset : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_found;
    assign o_match_offset = r_offset;

    `ASSERT_IMP(a_notfound_zero, i_clk, i_rst_n, r_out_valid && !r_found, r_offset == '0)
    `ASSERT_NXT(a_last_clears, i_clk, i_rst_n, s1_fire && r_s1_last, (r_count == '0) && !r_matched)
    `ASSERT_NXT(a_hit_reported, i_clk, i_rst_n, s1_fire && !r_matched && match.hit, r_out_valid && r_found)

endmodule
